[src/lwp_pkg.sv]
// Shared types, constants and helper functions for the LED wave pattern generator.
// Used by lwp_front, lwp_queue, lwp_back and led_wave_pattern_generator.
// Has no dependencies of its own.
`timescale 1ns / 1ps

package lwp_pkg;

  // Width of time_ms * beat_rate.
  localparam int PROD_W = 48;
  // Milliseconds in one minute, and the divisor that turns the remainder into a beat.
  localparam int MS_PER_MIN = 60000;
  localparam int BEAT_DIV = 1875;
  // Entries in the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Register map (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_BEAT_RATE  = 3'd0,
    REG_BRIGHTNESS = 3'd1,
    REG_LEVEL_MIN  = 3'd2,
    REG_LEVEL_MAX  = 3'd3,
    REG_PHASE_STEP = 3'd4,
    REG_BASE_COLOR = 3'd5,
    REG_DARK       = 3'd6
  } reg_idx_t;

  localparam logic [15:0] RST_BEAT_RATE  = 16'd45;
  localparam logic [7:0]  RST_BRIGHTNESS = 8'd30;
  localparam logic [7:0]  RST_LEVEL_MIN  = 8'd63;
  localparam logic [7:0]  RST_LEVEL_MAX  = 8'd255;
  localparam logic [7:0]  RST_PHASE_STEP = 8'd32;
  localparam logic [23:0] RST_BASE_COLOR = 24'h00BCD4;
  localparam logic        RST_DARK       = 1'b0;

  // One tick after the beat has been worked out.
  typedef struct packed {
    logic [7:0] beat;
    logic [2:0] sidx;
  } beat_item_t;

  // Configuration seen by the pixel pipeline.
  typedef struct packed {
    logic [7:0]  brightness;
    logic [7:0]  level_min;
    logic [7:0]  level_max;
    logic [7:0]  phase_step;
    logic [23:0] base_color;
  } pix_cfg_t;

  // Sideband that travels with each pixel down the pipeline.
  typedef struct packed {
    logic       strip;
    logic [3:0] idx;
    logic       last;
  } pix_tag_t;

  // First quarter of the sine wave, 0 to 64 inclusive.
  localparam logic [7:0] QUARTER_SINE [0:64] = '{
    8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149, 8'd152, 8'd155,
    8'd158, 8'd162, 8'd165, 8'd167, 8'd170, 8'd173, 8'd176, 8'd179, 8'd182, 8'd185,
    8'd188, 8'd190, 8'd193, 8'd196, 8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd211,
    8'd213, 8'd215, 8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
    8'd234, 8'd235, 8'd237, 8'd238, 8'd240, 8'd241, 8'd243, 8'd244, 8'd245, 8'd246,
    8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252, 8'd253, 8'd253, 8'd254, 8'd254,
    8'd254, 8'd255, 8'd255, 8'd255, 8'd255
  };

  // Full 256-point sine built from the quarter wave by symmetry.
  function automatic logic [7:0] sine_lookup(input logic [7:0] b);
    logic [7:0] mirror;
    logic [7:0] back;
    logic [7:0] neg;
    logic [7:0] val;
    mirror = 8'd128 - b;
    back   = b - 8'd128;
    neg    = 8'd0 - b;
    if (b <= 8'd64) begin
      val = QUARTER_SINE[b[6:0]];
    end else if (b < 8'd128) begin
      val = QUARTER_SINE[mirror[6:0]];
    end else if (b == 8'd128) begin
      val = 8'd127;
    end else if (b <= 8'd192) begin
      val = 8'd255 - QUARTER_SINE[back[6:0]];
    end else begin
      val = 8'd255 - QUARTER_SINE[neg[6:0]];
    end
    return val;
  endfunction

  // floor(x / 255) for x up to 255 * 255: estimate, then one correction step.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] est;
    logic [8:0]  q;
    logic [16:0] rem;
    est = {1'b0, x} + {9'd0, x[15:8]};
    q   = {1'b0, est[15:8]};
    rem = {1'b0, x} - (({8'd0, q} << 8) - {8'd0, q});
    if (rem >= 17'd255) begin
      q = q + 9'd1;
    end
    return q[7:0];
  endfunction

endpackage

[src/lwp_front.sv]
// Front part: accepts ticks and works out the beat phase of each one.
// Depends on lwp_pkg for widths, constants and the queue item type.
`timescale 1ns / 1ps

module lwp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         time_ms,
  input  logic [2:0]          status_index,
  input  logic [15:0]         beat_rate,
  input  logic                dark_enable,
  output logic                push_valid,
  input  logic                push_ready,
  output lwp_pkg::beat_item_t push_item
);
  import lwp_pkg::*;

  localparam int DIGITS = PROD_W / 4;
  localparam logic [3:0] LAST_DIGIT = 4'(DIGITS - 1);
  localparam int HI_DIV = BEAT_DIV * 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_QHI,
    ST_QLO,
    ST_PUSH
  } state_t;

  state_t              state;
  logic                hold_valid;
  logic [PROD_W-1:0]   hold_prod;
  logic [2:0]          hold_sidx;
  logic                take;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   shreg;
  logic [15:0]         rem;
  logic [3:0]          cnt;
  logic [14:0]         mrem;
  logic [7:0]          beat;
  logic [2:0]          sidx;
  logic [19:0]         wide;
  logic [3:0]          mod_dig;
  logic [15:0]         rem_next;
  logic [18:0]         scaled;
  logic [3:0]          hi_dig;
  logic [14:0]         mrem_next;
  logic [3:0]          lo_dig;

  assign prod     = {16'd0, time_ms} * {32'd0, beat_rate};
  assign take     = (state == ST_IDLE) && hold_valid;
  assign in_ready = !hold_valid || take;

  // Input holding stage: the product is formed as the tick is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= !dark_enable;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_prod <= prod;
      hold_sidx <= status_index;
    end
  end

  // Radix-16 remainder step modulo one minute.
  always_comb begin
    wide    = {rem, shreg[PROD_W-1 -: 4]};
    mod_dig = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (wide >= 20'(k * MS_PER_MIN)) begin
        mod_dig = 4'(k);
      end
    end
    rem_next = 16'(wide - 20'(mod_dig) * 20'(MS_PER_MIN));
  end

  // Beat = floor(8 * remainder / 1875), taken one hex digit at a time.
  always_comb begin
    scaled = {rem, 3'b000};
    hi_dig = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (scaled >= 19'(k * HI_DIV)) begin
        hi_dig = 4'(k);
      end
    end
    mrem_next = 15'(scaled - 19'(hi_dig) * 19'(HI_DIV));
    lo_dig = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (mrem >= 15'(k * BEAT_DIV)) begin
        lo_dig = 4'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= 4'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (hold_valid) begin
            shreg <= hold_prod;
            sidx  <= hold_sidx;
            rem   <= 16'd0;
            cnt   <= 4'd0;
            state <= ST_MOD;
          end
        end
        ST_MOD: begin
          rem   <= rem_next;
          shreg <= shreg << 4;
          cnt   <= cnt + 4'd1;
          if (cnt == LAST_DIGIT) begin
            state <= ST_QHI;
          end
        end
        ST_QHI: begin
          beat[7:4] <= hi_dig;
          mrem      <= mrem_next;
          state     <= ST_QLO;
        end
        ST_QLO: begin
          beat[3:0] <= lo_dig;
          state     <= ST_PUSH;
        end
        ST_PUSH: begin
          if (push_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign push_valid     = (state == ST_PUSH);
  assign push_item.beat = beat;
  assign push_item.sidx = sidx;

endmodule

[src/lwp_queue.sv]
// Short queue of beat items between the front and back parts.
// Depends on lwp_pkg for the item type and depth.
`timescale 1ns / 1ps

module lwp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  lwp_pkg::beat_item_t push_item,
  output logic                pop_valid,
  input  logic                pop,
  output lwp_pkg::beat_item_t pop_item
);
  import lwp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

  beat_item_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != FULL);
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

[src/lwp_back.sv]
// Back part: walks the pixels of each tick and scales them in a short pipeline.
// Depends on lwp_pkg for the sine table, divide-by-255 helper and struct types.
`timescale 1ns / 1ps

module lwp_back #(
  parameter int MAIN_COLS  = 4,
  parameter int MAIN_ROWS  = 4,
  parameter int STATUS_LEN = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  lwp_pkg::pix_cfg_t   cfg,
  input  logic                q_valid,
  input  lwp_pkg::beat_item_t q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                strip_select,
  output logic [3:0]          pixel_index,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue,
  output logic                last
);
  import lwp_pkg::*;

  localparam int NPIX  = MAIN_COLS * MAIN_ROWS;
  localparam int PIX_W = ($clog2(NPIX) > 4) ? $clog2(NPIX) : 4;
  localparam int ROW_W = (MAIN_ROWS > 1) ? $clog2(MAIN_ROWS) : 1;
  localparam logic [PIX_W-1:0] LAST_PIX = PIX_W'(NPIX - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MAIN_ROWS - 1);
  localparam logic [4:0] STATUS_LIM = 5'(STATUS_LEN);

  // Pixel walker.
  logic             active;
  logic             in_status;
  logic [PIX_W-1:0] pix;
  logic [ROW_W-1:0] row;
  logic [7:0]       phase;
  logic [7:0]       beat;
  logic [2:0]       sidx;
  logic             adv;
  logic             issue;
  logic             status_ok;
  logic             main_done;
  logic             seq_end;
  pix_tag_t         tag0;
  logic [7:0]       arg0;
  logic [7:0]       span;

  // Pipeline stages.
  logic             v1, v2, v3, v4, v5;
  pix_tag_t         tag1, tag2, tag3, tag4, tag5, tag_out;
  logic             st1, st2;
  logic [7:0]       arg1, arg2;
  logic [15:0]      wave2;
  logic [7:0]       k3;
  logic [2:0][15:0] pr4;
  logic [2:0]       nz4;
  logic [2:0][15:0] m5;
  logic [2:0][7:0]  rgb;
  logic [7:0]       k_next;
  logic [2:0][15:0] pr_next;
  logic [2:0]       nz_next;
  logic [2:0][15:0] m_next;
  logic [2:0][7:0]  rgb_next;
  logic [8:0]       r_sum;
  logic [7:0]       r_sat;
  logic [7:0]       comp;

  assign adv       = !out_valid || out_ready;
  assign issue     = active && adv;
  assign status_ok = ({2'b00, sidx} < STATUS_LIM);
  assign main_done = !in_status && (pix == LAST_PIX);
  assign seq_end   = issue && (in_status || (main_done && !status_ok));
  assign q_pop     = q_valid && (!active || seq_end);
  assign span      = (cfg.level_max >= cfg.level_min) ? cfg.level_max - cfg.level_min : 8'd0;

  always_comb begin
    if (in_status) begin
      tag0.strip = 1'b1;
      tag0.idx   = {1'b0, sidx};
      tag0.last  = 1'b1;
      arg0       = (8'd255 - beat) >> 1;
    end else begin
      tag0.strip = 1'b0;
      tag0.idx   = pix[3:0];
      tag0.last  = main_done && !status_ok;
      arg0       = phase;
    end
  end

  // Column-major walk; the phase steps on at each new column.
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      in_status <= 1'b0;
    end else if (q_pop) begin
      active    <= 1'b1;
      in_status <= 1'b0;
      pix       <= '0;
      row       <= '0;
      phase     <= q_item.beat;
      beat      <= q_item.beat;
      sidx      <= q_item.sidx;
    end else if (seq_end) begin
      active <= 1'b0;
    end else if (issue) begin
      if (main_done) begin
        in_status <= 1'b1;
      end else begin
        pix <= pix + 1'b1;
        if (row == LAST_ROW) begin
          row   <= '0;
          phase <= phase + cfg.phase_step;
        end else begin
          row <= row + 1'b1;
        end
      end
    end
  end

  always_comb begin
    k_next = st2 ? arg2 : cfg.level_min + div255(wave2);
    for (int i = 0; i < 3; i++) begin
      comp       = cfg.base_color[8 * (2 - i) +: 8];
      pr_next[i] = {8'd0, comp} * {8'd0, k3};
      nz_next[i] = (comp != 8'd0) && (k3 != 8'd0);
      r_sum      = {1'b0, pr4[i][15:8]} + {8'd0, nz4[i]};
      r_sat      = r_sum[8] ? 8'd255 : r_sum[7:0];
      m_next[i]  = {8'd0, r_sat} * {8'd0, cfg.brightness};
      rgb_next[i] = div255(m5[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= issue;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag1    <= tag0;
      st1     <= in_status;
      arg1    <= arg0;
      tag2    <= tag1;
      st2     <= st1;
      arg2    <= arg1;
      wave2   <= {8'd0, sine_lookup(arg1)} * {8'd0, span};
      tag3    <= tag2;
      k3      <= k_next;
      tag4    <= tag3;
      pr4     <= pr_next;
      nz4     <= nz_next;
      tag5    <= tag4;
      m5      <= m_next;
      tag_out <= tag5;
      rgb     <= rgb_next;
    end
  end

  assign strip_select = tag_out.strip;
  assign pixel_index  = tag_out.idx;
  assign last         = tag_out.last;
  assign red          = rgb[0];
  assign green        = rgb[1];
  assign blue         = rgb[2];

endmodule

[src/led_wave_pattern_generator.sv]
// Top level of the LED wave pattern generator: register file and the three parts.
// Depends on lwp_pkg, lwp_front, lwp_queue and lwp_back.
`timescale 1ns / 1ps

// Each tick transfer (time_ms, status_index) produces a burst of pixel transfers: all
// MAIN_COLS * MAIN_ROWS main pixels in column-major order, each column shown as
// base_color scaled by a sine breathing level, then one status-strip pixel at
// status_index when that index is below STATUS_LEN; last marks the final pixel
// of the burst. With dark_enable set a tick is taken and produces nothing.
// The output stream carries one pixel per clock while out_ready is high; that
// pixel walk is what sets the sustained rate.
// The beat phase is worked out ahead of that in a separate front part (one
// multiply, twelve radix-16 remainder steps modulo one minute, two quotient
// digits and a hand-off), and a two-entry queue lets a new tick be taken while
// the previous one is still being emitted. Registers should be written only
// while the block is idle; the block itself does not enforce this.
module led_wave_pattern_generator #(
  parameter int MAIN_COLS  = 4,
  parameter int MAIN_ROWS  = 4,
  parameter int STATUS_LEN = 6
) (
  input  logic        clk,
  input  logic        rst,
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Tick input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] time_ms,
  input  logic [2:0]  status_index,
  // Pixel output
  output logic        out_valid,
  input  logic        out_ready,
  output logic        strip_select,
  output logic [3:0]  pixel_index,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        last
);
  import lwp_pkg::*;

  logic [15:0] beat_rate;
  logic [7:0]  brightness;
  logic [7:0]  level_min;
  logic [7:0]  level_max;
  logic [7:0]  phase_step;
  logic [23:0] base_color;
  logic        dark_enable;

  reg_idx_t    reg_idx;
  logic        wr_en;
  pix_cfg_t    pix_cfg;

  logic        push_valid;
  logic        push_ready;
  beat_item_t  push_item;
  logic        q_valid;
  logic        q_pop;
  beat_item_t  q_item;

  // Registers sit on word boundaries, so the low two address bits are ignored.
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_rate   <= RST_BEAT_RATE;
      brightness  <= RST_BRIGHTNESS;
      level_min   <= RST_LEVEL_MIN;
      level_max   <= RST_LEVEL_MAX;
      phase_step  <= RST_PHASE_STEP;
      base_color  <= RST_BASE_COLOR;
      dark_enable <= RST_DARK;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BEAT_RATE:  beat_rate   <= pwdata[15:0];
        REG_BRIGHTNESS: brightness  <= pwdata[7:0];
        REG_LEVEL_MIN:  level_min   <= pwdata[7:0];
        REG_LEVEL_MAX:  level_max   <= pwdata[7:0];
        REG_PHASE_STEP: phase_step  <= pwdata[7:0];
        REG_BASE_COLOR: base_color  <= pwdata[23:0];
        REG_DARK:       dark_enable <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Read-back of the register selected by paddr; unmapped addresses read as zero.
  always_comb begin
    case (reg_idx)
      REG_BEAT_RATE:  prdata = {16'd0, beat_rate};
      REG_BRIGHTNESS: prdata = {24'd0, brightness};
      REG_LEVEL_MIN:  prdata = {24'd0, level_min};
      REG_LEVEL_MAX:  prdata = {24'd0, level_max};
      REG_PHASE_STEP: prdata = {24'd0, phase_step};
      REG_BASE_COLOR: prdata = {8'd0, base_color};
      REG_DARK:       prdata = {31'd0, dark_enable};
      default:        prdata = 32'd0;
    endcase
  end

  assign pix_cfg.brightness = brightness;
  assign pix_cfg.level_min  = level_min;
  assign pix_cfg.level_max  = level_max;
  assign pix_cfg.phase_step = phase_step;
  assign pix_cfg.base_color = base_color;

  // The front part takes ticks and turns the time into a beat phase.
  lwp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .time_ms      (time_ms),
    .status_index (status_index),
    .beat_rate    (beat_rate),
    .dark_enable  (dark_enable),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  // The queue lets the front part run ahead while pixels are still going out.
  lwp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  // The back part walks the pixels and scales them, one per clock while out_ready is high.
  lwp_back #(
    .MAIN_COLS  (MAIN_COLS),
    .MAIN_ROWS  (MAIN_ROWS),
    .STATUS_LEN (STATUS_LEN)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (pix_cfg),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .strip_select (strip_select),
    .pixel_index  (pixel_index),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .last         (last)
  );

endmodule
